[rtl/core/tse_pkg.sv]
// tone sequencer envelope: shared types, field widths and codes
// no dependencies; imported by every module of the block but tse_ram
package tse_pkg;

   localparam int CHAN_W  = 2;
   localparam int PITCH_W = 8;
   localparam int DUR_W   = 16;
   localparam int CNT_W   = 9;
   localparam int TIMER_W = 17;
   localparam int VOL_W   = 8;
   localparam int ENTRY_W = PITCH_W + DUR_W;
   localparam int MUL_W   = 16;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int STEP_W  = 13;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_START = 2'd2;

   localparam logic [1:0] REG_TICK_MS     = 2'd0;
   localparam logic [1:0] REG_REST_CODE   = 2'd1;
   localparam logic [1:0] REG_PITCH_MIN   = 2'd2;
   localparam logic [1:0] REG_PITCH_LIMIT = 2'd3;

   localparam logic [1:0] MODE_STOP = 2'd0;
   localparam logic [1:0] MODE_PLAY = 2'd1;
   localparam logic [1:0] MODE_END  = 2'd2;

   localparam logic KIND_PITCH  = 1'b0;
   localparam logic KIND_VOLUME = 1'b1;

   // x / 10 == (x * 52429) >> 19 for every 16-bit x
   localparam logic [MUL_W-1:0] DIV10_MUL   = 16'd52429;
   localparam int               DIV10_SHIFT = 19;

   // decay edges in units of the tenth-of-duration step
   localparam logic [MUL_W-1:0] EDGE_HALF    = 16'd6;
   localparam logic [MUL_W-1:0] EDGE_QUARTER = 16'd7;
   localparam logic [MUL_W-1:0] EDGE_EIGHTH  = 16'd9;

   typedef struct packed {
      logic [7:0] tick_ms;
      logic [7:0] rest_code;
      logic [7:0] pitch_min;
      logic [8:0] pitch_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [CHAN_W-1:0]  channel;
      logic [7:0]         entry_index;
      logic [PITCH_W-1:0] pitch;
      logic [DUR_W-1:0]   duration;
      logic [CNT_W-1:0]   note_count;
      logic               repeat_req;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic              kind;
      logic [7:0]        value;
   } res_type;

   typedef struct packed {
      logic    push;
      logic    flush;
      res_type res;
   } emit_type;

   typedef struct packed {
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_op_type;

endpackage

[rtl/core/tse_ram.sv]
// generic single-write, single-read memory with registered read data
// no package dependency
module tse_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 768,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/tse_mul.sv]
// shared 16x16 multiplier with registered product
// depends on tse_pkg
module tse_mul (
   input  logic                            clock,
   input  tse_pkg::mul_op_type             op,
   output logic [tse_pkg::PROD_W-1:0]      prod
);
   import tse_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op.a) * PROD_W'(op.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[rtl/core/tse_out.sv]
// result staging: one held word plus the output register
// the held word gets its last flag only once the tick is known to be done
// depends on tse_pkg
module tse_out (
   input  logic              clock,
   input  logic              reset,
   input  tse_pkg::emit_type emit,
   output logic              emit_ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,  // out_channel[1:0], write_value[9:2], zero pad
   output logic [0:0]        rsp_tuser,  // write_kind
   output logic              rsp_tlast
);
   import tse_pkg::*;

   logic    pend_valid_ff, pend_valid_in;
   res_type pend_ff, pend_in;
   logic    out_valid_ff, out_valid_in;
   res_type out_ff, out_in;
   logic    out_last_ff, out_last_in;
   logic    out_free;

   always_comb begin
      out_free      = !out_valid_ff || rsp_tready;
      emit_ready    = !pend_valid_ff || out_free;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      if (pend_valid_ff && out_free && (emit.push || emit.flush)) begin
         out_valid_in = 1'b1;
         out_in       = pend_ff;
         out_last_in  = emit.flush;
      end
      if (emit.push && emit_ready) begin
         pend_valid_in = 1'b1;
         pend_in       = emit.res;
      end else if (emit.flush && emit_ready) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_ff.value, out_ff.channel};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

endmodule

[rtl/core/tse_seq.sv]
// channel sequencer: per-channel play state and the tick walk over channels
// drives the note memory, the shared multiplier and the result stage; uses tse_pkg
module tse_seq #(
   parameter int CHANNELS          = 3,
   parameter int NOTES_PER_CHANNEL = 256,
   parameter int VOLUME_FULL       = 15,
   localparam int ADDR_W = (CHANNELS * NOTES_PER_CHANNEL > 1) ?
                           $clog2(CHANNELS * NOTES_PER_CHANNEL) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tse_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tse_pkg::req_type               req,
   output logic                           ram_we,
   output logic [ADDR_W-1:0]              ram_waddr,
   output logic [tse_pkg::ENTRY_W-1:0]    ram_wdata,
   output logic                           ram_re,
   output logic [ADDR_W-1:0]              ram_raddr,
   input  logic [tse_pkg::ENTRY_W-1:0]    ram_rdata,
   output tse_pkg::mul_op_type            mul_op,
   input  logic [tse_pkg::PROD_W-1:0]     mul_prod,
   output tse_pkg::emit_type              emit,
   input  logic                           emit_ready
);
   import tse_pkg::*;

   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [VOL_W-1:0] VOL_FULL    = VOL_W'(VOLUME_FULL);
   localparam logic [VOL_W-1:0] VOL_HALF    = VOL_W'(VOLUME_FULL / 2);
   localparam logic [VOL_W-1:0] VOL_QUARTER = VOL_W'(VOLUME_FULL / 4);
   localparam logic [VOL_W-1:0] VOL_EIGHTH  = VOL_W'(VOLUME_FULL / 8);
   localparam logic [CNT_W-1:0] COUNT_MAX   =
      CNT_W'((NOTES_PER_CHANNEL > 511) ? 511 : NOTES_PER_CHANNEL);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LOAD   = 4'd1;
   localparam logic [3:0] S_READ   = 4'd2;
   localparam logic [3:0] S_STEP   = 4'd3;
   localparam logic [3:0] S_CMP6   = 4'd4;
   localparam logic [3:0] S_CMP7   = 4'd5;
   localparam logic [3:0] S_CMP9   = 4'd6;
   localparam logic [3:0] S_EMIT_P = 4'd7;
   localparam logic [3:0] S_EMIT_V = 4'd8;
   localparam logic [3:0] S_FLUSH  = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [CW-1:0]     ch_ff, ch_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [1:0]         mode_ff  [CHANNELS];
   logic [1:0]         mode_in  [CHANNELS];
   logic               rep_ff   [CHANNELS];
   logic               rep_in   [CHANNELS];
   logic [CNT_W-1:0]   cnt_ff   [CHANNELS];
   logic [CNT_W-1:0]   cnt_in   [CHANNELS];
   logic [CNT_W-1:0]   pos_ff   [CHANNELS];
   logic [CNT_W-1:0]   pos_in   [CHANNELS];
   logic [TIMER_W-1:0] timer_ff [CHANNELS];
   logic [TIMER_W-1:0] timer_in [CHANNELS];
   logic [VOL_W-1:0]   vol_ff   [CHANNELS];
   logic [VOL_W-1:0]   vol_in   [CHANNELS];

   logic [CW-1:0]      req_chan;
   logic               chan_ok;
   logic [PITCH_W-1:0] note_pitch;
   logic [DUR_W-1:0]   note_dur;
   logic [TIMER_W-1:0] timer_sum;
   logic [CNT_W-1:0]   pos_next;
   logic [STEP_W-1:0]  step_now;
   logic               is_rest;
   logic               in_range;
   logic               timer_less;
   logic               last_ch;
   logic [3:0]         adv_state;
   logic [CW-1:0]      adv_ch;
   logic               lvl_done;
   logic [VOL_W-1:0]   lvl;

   assign req_chan   = CW'(req.channel);
   assign chan_ok    = int'(req.channel) < CHANNELS;
   assign note_pitch = ram_rdata[ENTRY_W-1:DUR_W];
   assign note_dur   = ram_rdata[DUR_W-1:0];
   assign timer_sum  = timer_ff[ch_ff] + TIMER_W'(cfg.tick_ms);
   assign pos_next   = pos_ff[ch_ff] + 1'b1;
   assign step_now   = mul_prod[DIV10_SHIFT +: STEP_W];
   assign is_rest    = note_pitch == cfg.rest_code;
   assign in_range   = (note_pitch >= cfg.pitch_min) && ({1'b0, note_pitch} < cfg.pitch_limit);
   assign timer_less = PROD_W'(timer_ff[ch_ff]) < mul_prod;
   assign last_ch    = ch_ff == CW'(CHANNELS - 1);
   assign adv_state  = last_ch ? S_FLUSH : S_LOAD;
   assign adv_ch     = last_ch ? ch_ff : ch_ff + 1'b1;
   assign req_ready  = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      step_in  = step_ff;
      mode_in  = mode_ff;
      rep_in   = rep_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      timer_in = timer_ff;
      vol_in   = vol_ff;

      ram_we    = 1'b0;
      ram_waddr = ADDR_W'(ADDR_W'(req_chan) * ADDR_W'(NOTES_PER_CHANNEL)
                  + ADDR_W'(req.entry_index));
      ram_wdata = {req.pitch, req.duration};
      ram_re    = 1'b0;
      ram_raddr = ADDR_W'(ADDR_W'(ch_ff) * ADDR_W'(NOTES_PER_CHANNEL)
                  + ADDR_W'(pos_ff[ch_ff]));

      mul_op.a = MUL_W'(step_ff);
      mul_op.b = '0;

      emit.push        = 1'b0;
      emit.flush       = 1'b0;
      emit.res.channel = CHAN_W'(ch_ff);
      emit.res.kind    = KIND_VOLUME;
      emit.res.value   = vol_ff[ch_ff];

      lvl_done = 1'b0;
      lvl      = VOL_EIGHTH;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req.command)
                  CMD_TICK: begin
                     ch_in    = '0;
                     state_in = S_LOAD;
                  end
                  CMD_WRITE: begin
                     if (chan_ok && (int'(req.entry_index) < NOTES_PER_CHANNEL)) begin
                        ram_we = 1'b1;
                     end
                  end
                  CMD_START: begin
                     if (chan_ok) begin
                        mode_in[req_chan]  = MODE_STOP;
                        rep_in[req_chan]   = 1'b0;
                        cnt_in[req_chan]   = '0;
                        pos_in[req_chan]   = '0;
                        timer_in[req_chan] = '0;
                        vol_in[req_chan]   = '0;
                        if (req.note_count != '0) begin
                           mode_in[req_chan] = MODE_PLAY;
                           rep_in[req_chan]  = req.repeat_req;
                           cnt_in[req_chan]  = (int'(req.note_count) > NOTES_PER_CHANNEL) ?
                                               COUNT_MAX : req.note_count;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_LOAD: begin
            case (mode_ff[ch_ff])
               MODE_STOP: begin
                  state_in = adv_state;
                  ch_in    = adv_ch;
               end
               MODE_END: begin
                  pos_in[ch_ff]   = '0;
                  timer_in[ch_ff] = '0;
                  if (!rep_ff[ch_ff]) begin
                     mode_in[ch_ff] = MODE_STOP;
                     cnt_in[ch_ff]  = '0;
                     vol_in[ch_ff]  = '0;
                     state_in       = S_EMIT_V;
                  end else begin
                     mode_in[ch_ff] = MODE_PLAY;
                     state_in       = adv_state;
                     ch_in          = adv_ch;
                  end
               end
               MODE_PLAY: begin
                  ram_re   = 1'b1;
                  state_in = S_READ;
               end
               default: begin
                  mode_in[ch_ff]  = MODE_STOP;
                  rep_in[ch_ff]   = 1'b0;
                  cnt_in[ch_ff]   = '0;
                  pos_in[ch_ff]   = '0;
                  timer_in[ch_ff] = '0;
                  vol_in[ch_ff]   = '0;
                  state_in        = adv_state;
                  ch_in           = adv_ch;
               end
            endcase
         end

         S_READ: begin
            timer_in[ch_ff] = timer_sum;
            if (timer_sum == TIMER_W'(cfg.tick_ms)) begin
               // note start
               if (!is_rest) begin
                  vol_in[ch_ff] = VOL_FULL;
                  state_in      = in_range ? S_EMIT_P : S_EMIT_V;
               end else begin
                  vol_in[ch_ff] = '0;
                  state_in      = S_EMIT_V;
               end
            end else if (timer_sum > TIMER_W'(note_dur)) begin
               timer_in[ch_ff] = '0;
               pos_in[ch_ff]   = pos_next;
               if (pos_next >= cnt_ff[ch_ff]) begin
                  mode_in[ch_ff] = MODE_END;
               end
               state_in = adv_state;
               ch_in    = adv_ch;
            end else if (!is_rest) begin
               mul_op.a = note_dur;
               mul_op.b = DIV10_MUL;
               state_in = S_STEP;
            end else begin
               state_in = adv_state;
               ch_in    = adv_ch;
            end
         end

         S_STEP: begin
            step_in = step_now;
            if (step_now == '0) begin
               lvl_done = 1'b1;
               lvl      = VOL_EIGHTH;
            end else begin
               mul_op.a = MUL_W'(step_now);
               mul_op.b = EDGE_HALF;
               state_in = S_CMP6;
            end
         end

         S_CMP6: begin
            if (timer_less) begin
               lvl_done = 1'b1;
               lvl      = VOL_FULL;
            end else begin
               mul_op.b = EDGE_QUARTER;
               state_in = S_CMP7;
            end
         end

         S_CMP7: begin
            if (timer_less) begin
               lvl_done = 1'b1;
               lvl      = VOL_HALF;
            end else begin
               mul_op.b = EDGE_EIGHTH;
               state_in = S_CMP9;
            end
         end

         S_CMP9: begin
            lvl_done = 1'b1;
            lvl      = timer_less ? VOL_QUARTER : VOL_EIGHTH;
         end

         S_EMIT_P: begin
            emit.push      = 1'b1;
            emit.res.kind  = KIND_PITCH;
            emit.res.value = note_pitch;
            if (emit_ready) begin
               state_in = S_EMIT_V;
            end
         end

         S_EMIT_V: begin
            emit.push = 1'b1;
            if (emit_ready) begin
               state_in = adv_state;
               ch_in    = adv_ch;
            end
         end

         S_FLUSH: begin
            emit.flush = 1'b1;
            if (emit_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // volume is written out only when the decay level changes
      if (lvl_done) begin
         if (lvl != vol_ff[ch_ff]) begin
            vol_in[ch_ff] = lvl;
            state_in      = S_EMIT_V;
         end else begin
            state_in = adv_state;
            ch_in    = adv_ch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ch_ff    <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            mode_ff[i]  <= MODE_STOP;
            rep_ff[i]   <= 1'b0;
            cnt_ff[i]   <= '0;
            pos_ff[i]   <= '0;
            timer_ff[i] <= '0;
            vol_ff[i]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         mode_ff  <= mode_in;
         rep_ff   <= rep_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         timer_ff <= timer_in;
         vol_ff   <= vol_in;
      end
      step_ff <= step_in;
   end

endmodule

[rtl/core/tone_sequencer_envelope.sv]
// Multi-channel note sequencer that emits pitch and volume register writes
// for a sound chip. Words come in on req_*: req_tuser holds the command
// (tick, write note entry, start channel job). Write and start words are
// handled in idle and give no result. A tick walks the channels in ascending
// order; each playing channel reads its current note from the note memory
// (one read port), steps its timer and, for the decay envelope, compares the
// timer against multiples of duration/10 on one shared multiplier. A stopped
// channel passes only the load state; a playing one passes load and read, and
// in decay step and compares at 6, 7 and 9 tenths as needed, plus an emit
// state per result word; a tick ends with a flush state. req_tready is low
// from the cycle after the tick is taken through the flush; the next word can
// be taken once the flush is accepted. Results leave on rsp_* with
// rsp_tuser as the write kind and rsp_tlast on the final word of a tick; up
// to two words wait on the output side, and when both are held the walk
// pauses at its next result and resumes without loss. A result held in the
// output register does not block the next request. Reset stops every
// channel and loads the register defaults; the note memory is not cleared
// and holds garbage until written. csr_* writes one register per cycle.
module tone_sequencer_envelope #(
   parameter int CHANNELS          = 3,
   parameter int NOTES_PER_CHANNEL = 256,
   parameter int VOLUME_FULL       = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // channel[1:0], entry_index[9:2], pitch[17:10],
                                   // duration[33:18], note_count[42:34], repeat_req[43], pad
   input  logic [1:0]  req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // out_channel[1:0], write_value[9:2], pad
   output logic [0:0]  rsp_tuser,  // write_kind
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [1:0]  csr_addr,
   input  logic [8:0]  csr_wdata
);
   import tse_pkg::*;

   localparam int DEPTH  = CHANNELS * NOTES_PER_CHANNEL;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cfg_type cfg_ff, cfg_in;
   req_type req;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0]  ram_wdata;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;
   mul_op_type          mul_op;
   logic [PROD_W-1:0]   mul_prod;
   emit_type            emit;
   logic                emit_ready;

   assign req.command     = req_tuser;
   assign req.channel     = req_tdata[1:0];
   assign req.entry_index = req_tdata[9:2];
   assign req.pitch       = req_tdata[17:10];
   assign req.duration    = req_tdata[33:18];
   assign req.note_count  = req_tdata[42:34];
   assign req.repeat_req  = req_tdata[43];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_addr)
            REG_TICK_MS:     cfg_in.tick_ms     = csr_wdata[7:0];
            REG_REST_CODE:   cfg_in.rest_code   = csr_wdata[7:0];
            REG_PITCH_MIN:   cfg_in.pitch_min   = csr_wdata[7:0];
            REG_PITCH_LIMIT: cfg_in.pitch_limit = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_ms     <= 8'd10;
         cfg_ff.rest_code   <= 8'd0;
         cfg_ff.pitch_min   <= 8'd0;
         cfg_ff.pitch_limit <= 9'd128;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tse_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_notes (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tse_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (mul_prod)
   );

   tse_seq #(
      .CHANNELS          (CHANNELS),
      .NOTES_PER_CHANNEL (NOTES_PER_CHANNEL),
      .VOLUME_FULL       (VOLUME_FULL)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .mul_op     (mul_op),
      .mul_prod   (mul_prod),
      .emit       (emit),
      .emit_ready (emit_ready)
   );

   tse_out u_out (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .emit_ready (emit_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[bench/tb.sv]
// testbench for tone_sequencer_envelope: directed note lists, job control, output stall
// and random traffic under several register settings, checked against an in-bench predictor
// depends on tse_pkg and the tone_sequencer_envelope top level
module tb;
   import tse_pkg::*;

   localparam int CHANNELS          = 3;
   localparam int NOTES_PER_CHANNEL = 256;
   localparam int VOLUME_FULL       = 15;
   localparam int HOLD_CYCLES       = 300;
   localparam int SETTLE_CYCLES     = 40;
   localparam int WATCHDOG_LIMIT    = 3000;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] NO_CHANNEL = 2'd3;

   typedef struct packed {
      logic [7:0]  pitch;
      logic [15:0] duration;
   } note_entry_type;

   typedef struct packed {
      logic [1:0] chan;
      logic       kind;
      logic [7:0] value;
      logic       last;
   } chip_write_type;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_style_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wen;
   logic [1:0]  csr_addr;
   logic [8:0]  csr_wdata;

   // predictor state
   cfg_type        chip_cfg;
   note_entry_type note_mem [CHANNELS][NOTES_PER_CHANNEL];
   bit             note_written [CHANNELS][NOTES_PER_CHANNEL];
   logic [1:0]     mode_now [CHANNELS];
   bit             looping [CHANNELS];
   int unsigned    notes_in_job [CHANNELS];
   int unsigned    note_pos [CHANNELS];
   int unsigned    elapsed_ms [CHANNELS];
   logic [7:0]     volume_now [CHANNELS];

   chip_write_type tick_batch[$];
   chip_write_type chip_writes_due[$];

   int unsigned mismatches   = 0;
   int unsigned payload_sent = 0;
   int unsigned burst_left   = 0;
   bit          hold_request = 1'b0;

   always #5 clock = ~clock;

   tone_sequencer_envelope #(
      .CHANNELS          (CHANNELS),
      .NOTES_PER_CHANNEL (NOTES_PER_CHANNEL),
      .VOLUME_FULL       (VOLUME_FULL)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------- predictor

   function automatic void clear_channel(int ch);
      mode_now[ch]     = MODE_STOP;
      looping[ch]      = 1'b0;
      notes_in_job[ch] = 0;
      note_pos[ch]     = 0;
      elapsed_ms[ch]   = 0;
      volume_now[ch]   = 8'd0;
   endfunction

   function automatic void queue_write(int ch, logic kind, logic [7:0] value);
      tick_batch.push_back('{chan: 2'(ch), kind: kind, value: value, last: 1'b0});
   endfunction

   function automatic logic [7:0] decay_volume(int unsigned elapsed, int unsigned span);
      int unsigned tenth;
      int unsigned tenths_done;
      tenth = span / 10;
      // very short notes go straight to the quietest level
      if (tenth == 0) return 8'(VOLUME_FULL / 8);
      tenths_done = elapsed / tenth;
      if (tenths_done <= 5) return 8'(VOLUME_FULL);
      if (tenths_done <= 6) return 8'(VOLUME_FULL / 2);
      if (tenths_done <= 8) return 8'(VOLUME_FULL / 4);
      return 8'(VOLUME_FULL / 8);
   endfunction

   function automatic void step_channel(int ch);
      note_entry_type nt;
      logic [7:0]     lvl;
      if (mode_now[ch] == MODE_END) begin
         if (!looping[ch]) begin
            clear_channel(ch);
            queue_write(ch, KIND_VOLUME, 8'd0);
         end else begin
            mode_now[ch]   = MODE_PLAY;
            note_pos[ch]   = 0;
            elapsed_ms[ch] = 0;
         end
      end else if (mode_now[ch] == MODE_PLAY) begin
         nt = note_mem[ch][note_pos[ch] % NOTES_PER_CHANNEL];
         elapsed_ms[ch] = (elapsed_ms[ch] + chip_cfg.tick_ms) & 32'h1FFFF;
         // note start is detected by the timer landing exactly on one tick
         if (elapsed_ms[ch] == chip_cfg.tick_ms) begin
            if (nt.pitch != chip_cfg.rest_code) begin
               if (nt.pitch >= chip_cfg.pitch_min && nt.pitch < chip_cfg.pitch_limit)
                  queue_write(ch, KIND_PITCH, nt.pitch);
               volume_now[ch] = 8'(VOLUME_FULL);
            end else begin
               volume_now[ch] = 8'd0;
            end
            queue_write(ch, KIND_VOLUME, volume_now[ch]);
         end else if (elapsed_ms[ch] > nt.duration) begin
            elapsed_ms[ch] = 0;
            note_pos[ch]   = (note_pos[ch] + 1) & 32'h1FF;
            if (note_pos[ch] >= notes_in_job[ch]) mode_now[ch] = MODE_END;
         end else if (nt.pitch != chip_cfg.rest_code) begin
            lvl = decay_volume(elapsed_ms[ch], nt.duration);
            if (lvl != volume_now[ch]) begin
               volume_now[ch] = lvl;
               queue_write(ch, KIND_VOLUME, lvl);
            end
         end
      end
   endfunction

   function automatic void predict_word(req_type w);
      int unsigned jobs;
      if (w.command == CMD_TICK) begin
         tick_batch.delete();
         for (int ch = 0; ch < CHANNELS; ch++) step_channel(ch);
         if (tick_batch.size() > 0) tick_batch[tick_batch.size() - 1].last = 1'b1;
         foreach (tick_batch[i]) chip_writes_due.push_back(tick_batch[i]);
      end else if (w.channel < CHANNELS) begin
         if (w.command == CMD_WRITE) begin
            note_mem[w.channel][w.entry_index]     = '{pitch: w.pitch, duration: w.duration};
            note_written[w.channel][w.entry_index] = 1'b1;
         end else if (w.command == CMD_START) begin
            clear_channel(w.channel);
            if (w.note_count != 0) begin
               jobs = (w.note_count > NOTES_PER_CHANNEL) ? NOTES_PER_CHANNEL : w.note_count;
               looping[w.channel]      = w.repeat_req;
               notes_in_job[w.channel] = jobs;
               mode_now[w.channel]     = MODE_PLAY;
            end
         end
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic [7:0] pick_pitch();
      int unsigned roll;
      int unsigned top;
      roll = $urandom_range(0, 9);
      top  = ((chip_cfg.pitch_limit > 256) ? 256 : chip_cfg.pitch_limit) - 1;
      if (roll < 2) return chip_cfg.rest_code;
      if (roll < 7 && chip_cfg.pitch_limit > chip_cfg.pitch_min)
         return 8'($urandom_range(chip_cfg.pitch_min, top));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [15:0] pick_duration();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 16'($urandom_range(0, 65535));
      if (roll == 1) return 16'd0;
      return 16'(chip_cfg.tick_ms * $urandom_range(0, 14) + $urandom_range(0, chip_cfg.tick_ms));
   endfunction

   function automatic req_type random_word();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   task automatic send_word(input req_type w);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, w.repeat_req, w.note_count, w.duration, w.pitch, w.entry_index,
                     w.channel};
      req_tuser  <= w.command;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (w.command == CMD_TICK
          || ((w.command == CMD_WRITE || w.command == CMD_START) && w.channel < CHANNELS))
         payload_sent++;
      predict_word(w);
   endtask

   task automatic send_note(int ch, int idx, logic [7:0] pitch, logic [15:0] duration);
      req_type w;
      w             = random_word();
      w.command     = CMD_WRITE;
      w.channel     = 2'(ch);
      w.entry_index = 8'(idx);
      w.pitch       = pitch;
      w.duration    = duration;
      send_word(w);
   endtask

   task automatic send_start(int ch, int unsigned count, bit rep);
      req_type w;
      w            = random_word();
      w.command    = CMD_START;
      w.channel    = 2'(ch);
      w.note_count = 9'(count);
      w.repeat_req = rep;
      send_word(w);
   endtask

   // a playing channel must never fetch a note slot that was never loaded
   task automatic send_tick();
      req_type w;
      for (int ch = 0; ch < CHANNELS; ch++)
         if (mode_now[ch] == MODE_PLAY && !note_written[ch][note_pos[ch] % NOTES_PER_CHANNEL])
            send_note(ch, note_pos[ch] % NOTES_PER_CHANNEL, pick_pitch(), pick_duration());
      w         = random_word();
      w.command = CMD_TICK;
      send_word(w);
   endtask

   task automatic load_job(int ch);
      int unsigned len;
      int unsigned roll;
      int unsigned count;
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) send_note(ch, i, pick_pitch(), pick_duration());
      roll = $urandom_range(0, 9);
      if (roll == 0) count = $urandom_range(NOTES_PER_CHANNEL + 1, 511);
      else if (roll == 1) count = NOTES_PER_CHANNEL;
      else if (roll == 2) count = len + $urandom_range(1, 3);
      else count = len;
      send_start(ch, count, $urandom_range(0, 1));
   endtask

   task automatic send_stray_word();
      req_type w;
      w = random_word();
      case ($urandom_range(0, 3))
         0: w.command = CMD_UNUSED;
         1: begin
            w.command = ($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_START;
            w.channel = NO_CHANNEL;
         end
         2: begin
            w.command = CMD_WRITE;
            w.channel = 2'($urandom_range(0, CHANNELS - 1));
         end
         default: begin
            w.command    = CMD_START;
            w.channel    = 2'($urandom_range(0, CHANNELS - 1));
            w.note_count = '0;
         end
      endcase
      send_word(w);
   endtask

   task automatic random_traffic(int unsigned words);
      int unsigned goal;
      int unsigned roll;
      goal = payload_sent + words;
      while (payload_sent < goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 25) load_job($urandom_range(0, CHANNELS - 1));
         else if (roll < 90) repeat ($urandom_range(1, 8)) send_tick();
         else send_stray_word();
      end
   endtask

   // a tick with no writes may still be walking channels after the last word
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (chip_writes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] addr, logic [8:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      case (addr)
         REG_TICK_MS:     chip_cfg.tick_ms     = value[7:0];
         REG_REST_CODE:   chip_cfg.rest_code   = value[7:0];
         REG_PITCH_MIN:   chip_cfg.pitch_min   = value[7:0];
         REG_PITCH_LIMIT: chip_cfg.pitch_limit = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(cfg_type s);
      wait_idle();
      write_register(REG_TICK_MS, s.tick_ms);
      write_register(REG_REST_CODE, s.rest_code);
      write_register(REG_PITCH_MIN, s.pitch_min);
      write_register(REG_PITCH_LIMIT, s.pitch_limit);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // decay steps, a rest, a pitch above the limit and a very short note
   task automatic test_decay_envelope();
      send_note(0, 0, 8'd60, 16'd50);
      send_note(0, 1, chip_cfg.rest_code, 16'd20);
      send_note(0, 2, 8'd200, 16'd5);
      send_note(1, 0, 8'd127, 16'd30);
      send_start(0, 3, 1'b0);
      send_start(1, 1, 1'b0);
      repeat (12) send_tick();
   endtask

   // count saturation, stop by zero count, looping, ignored words
   task automatic test_job_control();
      req_type w;
      send_note(1, 255, 8'd255, 16'hFFFF);
      send_note(2, 0, 8'd1, 16'd0);
      send_start(1, 511, 1'b1);
      send_start(1, 0, 1'b1);
      send_start(2, 1, 1'b1);
      repeat (4) send_tick();
      send_start(2, 0, 1'b0);
      send_tick();
      w         = random_word();
      w.command = CMD_UNUSED;
      send_word(w);
      w         = random_word();
      w.command = CMD_WRITE;
      w.channel = NO_CHANNEL;
      send_word(w);
   endtask

   // receiver holds off while ticks keep coming so the block backs up
   task automatic test_output_stall();
      for (int ch = 0; ch < CHANNELS; ch++) load_job(ch);
      hold_request = 1'b1;
      repeat (10) send_tick();
   endtask

   task automatic test_settings_sweep();
      cfg_type plan [5];
      int unsigned budget [5];
      plan[0] = '{tick_ms: 8'd10, rest_code: 8'd0, pitch_min: 8'd0, pitch_limit: 9'd128};
      plan[1] = '{tick_ms: 8'd255, rest_code: 8'd255, pitch_min: 8'd255, pitch_limit: 9'd256};
      plan[2] = '{tick_ms: 8'd1, rest_code: 8'd7, pitch_min: 8'd20, pitch_limit: 9'd0};
      plan[3] = '{tick_ms: 8'd0, rest_code: 8'd3, pitch_min: 8'd0, pitch_limit: 9'd256};
      plan[4] = '{tick_ms: 8'($urandom_range(1, 255)), rest_code: 8'($urandom_range(0, 255)),
                  pitch_min: 8'($urandom_range(0, 255)), pitch_limit: 9'($urandom_range(0, 256))};
      budget  = '{18, 18, 18, 18, 24};
      for (int i = 0; i < 5; i++) begin
         apply_settings(plan[i]);
         random_traffic(budget[i]);
      end
   endtask

   // ---------------------------------------------------------------- processes

   function automatic bit count_mismatch();
      mismatches++;
      return mismatches <= 10;
   endfunction

   initial begin : write_checker
      chip_write_type got;
      chip_write_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{chan: rsp_tdata[1:0], kind: rsp_tuser[0], value: rsp_tdata[9:2],
                    last: rsp_tlast};
            if (chip_writes_due.size() == 0) begin
               if (count_mismatch())
                  $display("%0t: write with none due: ch %0d kind %0d value %0d last %0d",
                           $realtime, got.chan, got.kind, got.value, got.last);
            end else begin
               want = chip_writes_due.pop_front();
               if (got.chan !== want.chan || got.kind !== want.kind
                   || got.value !== want.value || got.last !== want.last) begin
                  if (count_mismatch())
                     $display("%0t: word mismatch: want ch %0d kind %0d value %0d last %0d,",
                              $realtime, want.chan, want.kind, want.value, want.last,
                              " got ch %0d kind %0d value %0d last %0d",
                              got.chan, got.kind, got.value, got.last);
               end
            end
         end
      end
   end

   initial begin : receiver
      stall_style_type style;
      int unsigned     epoch_left;
      int unsigned     beat;
      style      = STALL_NONE;
      epoch_left = 0;
      beat       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (epoch_left == 0) begin
               style      = stall_style_type'($urandom_range(0, 2));
               epoch_left = $urandom_range(16, 96);
            end
            epoch_left--;
            beat++;
            case (style)
               STALL_NONE:   rsp_tready <= 1'b1;
               STALL_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
               default:      rsp_tready <= (beat % 7 >= 3);
            endcase
         end
      end
   end

   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_TICK;
      csr_wen    = 1'b0;
      csr_addr   = REG_TICK_MS;
      csr_wdata  = '0;
      chip_cfg   = '{tick_ms: 8'd10, rest_code: 8'd0, pitch_min: 8'd0, pitch_limit: 9'd128};
      for (int ch = 0; ch < CHANNELS; ch++) clear_channel(ch);
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_decay_envelope();
      test_job_control();
      test_output_stall();
      test_settings_sweep();

      wait_idle();
      if (mismatches == 0 && chip_writes_due.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
